// ===== design/cnms_pkg.sv =====
// cnms_pkg: shared codes, register map and result type for corner_threshold_nms
// no dependencies; imported by the top level

package cnms_pkg;

    // input beat kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_THRESHOLD    = 2'd2;

    // register reset values
    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd512;
    localparam logic [10:0] FRAME_HEIGHT_RST = 11'd512;
    localparam logic [31:0] THRESHOLD_RST    = 32'd0;

    // smallest frame side that is accepted
    localparam int MIN_DIM = 3;

    // result queue depth and pointer width
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = 2;

    typedef struct packed {
        logic       last;
        logic [9:0] y;
        logic [9:0] x;
        logic       corner;
    } res_t;

endpackage

// ===== design/corner_threshold_nms.sv =====
// corner_threshold_nms: threshold plus square-window non-maximum suppression
// over a raster response map with mirrored borders; uses cnms_pkg
//
// channel   dir  beat fields (lowest bit first)
// s_*       in   tuser: kind; tdata: response[31:0]
// m_*       out  tdata: is_corner, pos_x[9:0], pos_y[9:0], zero fill; tlast: frame_last
// apb       cfg  0x0 frame_width, 0x4 frame_height, 0x8 threshold
//
// one input beat per clock while s_tready is high; a result reaches the output queue
// by way of the line-store read register, the column history and the
// compare stage. results trail the input by RADIUS rows plus RADIUS pixels, and
// drain beats flush the last rows. s_tready drops only when the output queue plus
// results in flight would fill it; the pipeline itself never stalls.
// reset clears counters, flags and queue state; line-store contents stay undefined.

module corner_threshold_nms
    import cnms_pkg::*;
#(
    parameter int RADIUS      = 2,
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // response[31:0]
    input  logic        s_tuser,    // kind
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // is_corner, pos_x[9:0], pos_y[9:0], 3 zero bits
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SB        = SAMPLE_BITS;
    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int RW        = $clog2(MAX_HEIGHT);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int HW        = $clog2(MAX_HEIGHT + 1);
    localparam int DW        = (WW > HW) ? WW : HW;
    localparam int FW        = DW + 3;
    localparam int XW        = DW + 2;
    localparam int LINE_ROWS = 2 * RADIUS + 2;
    localparam int BW        = $clog2(LINE_ROWS);
    localparam int WIN       = 2 * RADIUS + 1;
    localparam int HIST      = 3 * RADIUS + 1;
    localparam int RRW       = RW + 1;

    // control that travels with a result through the pipeline
    typedef struct packed {
        logic [HIST-1:0]      used;    // history columns inside the window
        logic [LINE_ROWS-1:0] bmask;   // line banks holding window rows
        logic [BW-1:0]        ownb;    // bank of the center row
        logic [9:0]           x;
        logic [9:0]           y;
        logic                 last;
    } emit_ctl_t;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic int clamp_dim(input logic [10:0] d, input int maxv);
        int v;
        v = int'(d);
        if (v < MIN_DIM)
        begin
            v = MIN_DIM;
        end
        else if (v > maxv)
        begin
            v = maxv;
        end
        return v;
    endfunction

    // mirror an index into 0..n-1 without repeating the edge sample
    function automatic logic [DW-1:0] fold_idx(input logic signed [FW-1:0] i,
                                               input logic [DW-1:0] n);
        logic signed [FW-1:0] p;
        logic signed [FW-1:0] m;
        logic signed [FW-1:0] top;
        p   = $signed({2'b00, n, 1'b0}) - $signed(FW'(2));
        top = $signed({3'b000, n}) - $signed(FW'(1));
        m   = i;
        if (m < 0)
        begin
            m = m + p;
        end
        if (m >= p)
        begin
            m = m - p;
        end
        if (m > top)
        begin
            m = p - m;
        end
        return m[DW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [10:0] cfg_w_reg;
    logic [10:0] cfg_h_reg;
    logic [31:0] thr_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg <= FRAME_WIDTH_RST;
            cfg_h_reg <= FRAME_HEIGHT_RST;
            thr_reg   <= THRESHOLD_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_FRAME_WIDTH:  cfg_w_reg <= pwdata[10:0];
                REG_FRAME_HEIGHT: cfg_h_reg <= pwdata[10:0];
                REG_THRESHOLD:    thr_reg   <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = {21'd0, cfg_w_reg};
            REG_FRAME_HEIGHT: prdata = {21'd0, cfg_h_reg};
            REG_THRESHOLD:    prdata = thr_reg;
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // raster counters
    // ------------------------------------------------------------------
    logic [WW-1:0]  fw_reg, fw_next, fw_cur;
    logic [HW-1:0]  fh_reg, fh_next, fh_cur;
    logic [CW-1:0]  in_col_reg, in_col_next;
    logic [RW-1:0]  in_row_reg, in_row_next;
    logic           in_done_reg, in_done_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [RW-1:0]  out_row_reg, out_row_next;
    logic [CW-1:0]  rd_col_reg, rd_col_next;
    logic [RRW-1:0] rd_row_reg, rd_row_next;
    logic [BW-1:0]  wr_bank_reg, wr_bank_next;
    logic [RW-1:0]  tag_reg [LINE_ROWS];

    logic acc, sample_ok, start, read0, emit0, last0;
    logic col_wrap, row_end, rd_wrap, out_wrap;
    logic signed [SB-1:0] samp;
    logic cand;

    assign acc  = s_tvalid && s_tready;
    assign samp = s_tdata[SB-1:0];
    assign cand = $signed(32'(samp)) > $signed(thr_reg);

    always_comb
    begin
        sample_ok = (s_tuser == KIND_SAMPLE) && !in_done_reg;
        start     = (in_row_reg == '0) && (in_col_reg == '0);
        // frame size latches at the first sample of a frame
        fw_cur = (sample_ok && start) ? WW'(clamp_dim(cfg_w_reg, MAX_WIDTH)) : fw_reg;
        fh_cur = (sample_ok && start) ? HW'(clamp_dim(cfg_h_reg, MAX_HEIGHT)) : fh_reg;

        col_wrap = (XW'(in_col_reg) + XW'(1)) >= XW'(fw_cur);
        row_end  = (XW'(in_row_reg) + XW'(1)) >= XW'(fh_cur);
        rd_wrap  = (XW'(rd_col_reg) + XW'(1)) >= XW'(fw_cur);
        out_wrap = (XW'(out_col_reg) + XW'(1)) >= XW'(fw_cur);
        last0    = ((XW'(out_row_reg) + XW'(1)) >= XW'(fh_cur)) && out_wrap;

        // reads start RADIUS rows in; results start RADIUS pixels later
        read0 = sample_ok ? (in_row_reg >= RW'(RADIUS)) : in_done_reg;
        emit0 = sample_ok ? ((in_row_reg > RW'(RADIUS)) ||
                             ((in_row_reg == RW'(RADIUS)) && (in_col_reg >= CW'(RADIUS))))
                          : in_done_reg;

        fw_next      = fw_reg;
        fh_next      = fh_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_done_next = in_done_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        rd_col_next  = rd_col_reg;
        rd_row_next  = rd_row_reg;
        wr_bank_next = wr_bank_reg;

        if (acc)
        begin
            fw_next = fw_cur;
            fh_next = fh_cur;
            if (sample_ok)
            begin
                if (col_wrap)
                begin
                    in_col_next  = '0;
                    wr_bank_next = (wr_bank_reg == BW'(LINE_ROWS - 1)) ? '0
                                                                       : wr_bank_reg + 1'b1;
                    if (row_end)
                    begin
                        in_done_next = 1'b1;
                    end
                    else
                    begin
                        in_row_next = in_row_reg + 1'b1;
                    end
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
            if (read0)
            begin
                if (rd_wrap)
                begin
                    rd_col_next = '0;
                    rd_row_next = rd_row_reg + 1'b1;
                end
                else
                begin
                    rd_col_next = rd_col_reg + 1'b1;
                end
            end
            if (emit0)
            begin
                if (last0)
                begin
                    // frame finished: rewind everything for the next one
                    in_col_next  = '0;
                    in_row_next  = '0;
                    in_done_next = 1'b0;
                    out_col_next = '0;
                    out_row_next = '0;
                    rd_col_next  = '0;
                    rd_row_next  = '0;
                    wr_bank_next = '0;
                end
                else if (out_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg      <= WW'(clamp_dim(FRAME_WIDTH_RST, MAX_WIDTH));
            fh_reg      <= HW'(clamp_dim(FRAME_HEIGHT_RST, MAX_HEIGHT));
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_done_reg <= 1'b0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            rd_col_reg  <= '0;
            rd_row_reg  <= '0;
            wr_bank_reg <= '0;
            for (int b = 0; b < LINE_ROWS; b++)
            begin
                tag_reg[b] <= RW'(b);
            end
        end
        else
        begin
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_done_reg <= in_done_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            rd_col_reg  <= rd_col_next;
            rd_row_reg  <= rd_row_next;
            wr_bank_reg <= wr_bank_next;
            if (acc && sample_ok)
            begin
                tag_reg[wr_bank_reg] <= in_row_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // window geometry for the result issued by this beat
    // ------------------------------------------------------------------
    emit_ctl_t ctl0;

    always_comb
    begin
        logic [DW-1:0]        fc;
        logic [DW-1:0]        fr;
        logic signed [FW-1:0] jv;
        ctl0 = '0;
        // columns: history slot j holds column out_col + RADIUS - j
        for (int l = 0; l < WIN; l++)
        begin
            fc = fold_idx($signed(FW'(out_col_reg)) + $signed(FW'(l - RADIUS)), DW'(fw_cur));
            jv = $signed(FW'(out_col_reg)) + $signed(FW'(RADIUS)) - $signed(FW'(fc));
            for (int j = 0; j < HIST; j++)
            begin
                if (jv == $signed(FW'(j)))
                begin
                    ctl0.used[j] = 1'b1;
                end
            end
        end
        // rows: find the banks that hold the mirrored window rows
        for (int k = 0; k < WIN; k++)
        begin
            fr = fold_idx($signed(FW'(out_row_reg)) + $signed(FW'(k - RADIUS)), DW'(fh_cur));
            for (int b = 0; b < LINE_ROWS; b++)
            begin
                if (DW'(tag_reg[b]) == fr)
                begin
                    ctl0.bmask[b] = 1'b1;
                end
            end
        end
        for (int b = 0; b < LINE_ROWS; b++)
        begin
            if (tag_reg[b] == out_row_reg)
            begin
                ctl0.ownb = BW'(b);
            end
        end
        ctl0.x    = 10'(out_col_reg);
        ctl0.y    = 10'(out_row_reg);
        ctl0.last = last0;
    end

    // ------------------------------------------------------------------
    // line store: one bank per ring row, all banks read at one column
    // ------------------------------------------------------------------
    logic [SB:0] line_mem [LINE_ROWS][MAX_WIDTH];
    logic [SB:0] dout_reg [LINE_ROWS];

    always_ff @(posedge clk)
    begin
        if (acc && sample_ok)
        begin
            line_mem[wr_bank_reg][in_col_reg] <= {cand, cand ? samp : SB'(0)};
        end
        if (acc && read0)
        begin
            for (int b = 0; b < LINE_ROWS; b++)
            begin
                dout_reg[b] <= line_mem[b][rd_col_reg];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1: bypass the sample being written, shift the column history
    // ------------------------------------------------------------------
    logic            read1_reg, emit1_reg, byp1_reg;
    logic [BW-1:0]   bypb1_reg;
    logic [SB:0]     bypd1_reg;
    emit_ctl_t       ctl1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read1_reg <= 1'b0;
            emit1_reg <= 1'b0;
        end
        else
        begin
            read1_reg <= acc && read0;
            emit1_reg <= acc && emit0;
        end
    end

    always_ff @(posedge clk)
    begin
        // the read column always equals the write column when both happen
        byp1_reg  <= sample_ok;
        bypb1_reg <= wr_bank_reg;
        bypd1_reg <= {cand, cand ? samp : SB'(0)};
        ctl1_reg  <= ctl0;
    end

    logic [SB:0] hist_reg [HIST][LINE_ROWS];
    logic        emit2_reg;
    emit_ctl_t   ctl2_reg;

    always_ff @(posedge clk)
    begin
        if (read1_reg)
        begin
            for (int j = HIST - 1; j > 0; j--)
            begin
                hist_reg[j] <= hist_reg[j - 1];
            end
            for (int b = 0; b < LINE_ROWS; b++)
            begin
                hist_reg[0][b] <= (byp1_reg && (bypb1_reg == BW'(b))) ? bypd1_reg
                                                                       : dout_reg[b];
            end
        end
        ctl2_reg <= ctl1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit2_reg <= 1'b0;
        end
        else
        begin
            emit2_reg <= emit1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: compare every window sample against the center
    // ------------------------------------------------------------------
    logic [SB:0] own;
    logic        greater;
    res_t        res2;

    always_comb
    begin
        own     = hist_reg[RADIUS][ctl2_reg.ownb];
        greater = 1'b0;
        for (int j = 0; j < HIST; j++)
        begin
            for (int b = 0; b < LINE_ROWS; b++)
            begin
                if (ctl2_reg.used[j] && ctl2_reg.bmask[b] &&
                    ($signed(hist_reg[j][b][SB-1:0]) > $signed(own[SB-1:0])))
                begin
                    greater = 1'b1;
                end
            end
        end
        res2.corner = own[SB] && !greater;
        res2.x      = ctl2_reg.x;
        res2.y      = ctl2_reg.y;
        res2.last   = ctl2_reg.last;
    end

    // ------------------------------------------------------------------
    // output queue with credit-based input ready
    // ------------------------------------------------------------------
    localparam int CNTW = $clog2(FIFO_DEPTH + 1);

    res_t               fifo_reg [FIFO_DEPTH];
    logic [FIFO_PW-1:0] wp_reg, rp_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic               push, pop;
    res_t               head;

    assign push     = emit2_reg;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != '0);
    assign head     = fifo_reg[rp_reg];
    assign m_tdata  = {3'b000, head.y, head.x, head.corner};
    assign m_tlast  = head.last;
    assign s_tready = ((CNTW + 1)'(cnt_reg) + (CNTW + 1)'(emit1_reg) + (CNTW + 1)'(emit2_reg))
                      < (CNTW + 1)'(FIFO_DEPTH);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wp_reg] <= res2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule
